// ===== hw/rtl/sdtq_pkg.sv =====
// Shared constants and types for the sorted deadline timer queue.
package sdtq_pkg;

  // Defaults for the top-level parameters
  localparam int DefQueueDepth = 16;
  localparam int DefHandleBits = 8;

  // Field widths fixed by the interface
  localparam int TickBits    = 32;
  localparam int PortHandleW = 8;
  localparam int PeriodBits  = 8;

  // Reset value of the task switch period
  localparam logic [PeriodBits-1:0] PeriodReset = 8'd10;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_SWITCH  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

endpackage

// ===== hw/rtl/sdtq_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
module sdtq_ram import sdtq_pkg::*; #(
  parameter int DEPTH  = DefQueueDepth,
  parameter int DATA_W = TickBits + DefHandleBits,
  parameter int ADDR_W = $clog2(DefQueueDepth)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sorted_deadline_timer_queue.sv =====
// Top level of the sorted deadline timer queue.
//
// Usage:
//   Requests come in on start/mode/handle/delay and are taken at a clock edge
//   with start high and busy low. mode 0 sets a timer at tick_count + delay;
//   mode 1 is one clock tick. Results leave on kind/expired_handle/last, each
//   marked by result_valid for exactly one cycle; the receiver cannot stall,
//   so every result is taken in the cycle it is shown. last marks the final
//   result of a request.
//   switch_period is written through cfg_we/cfg_wdata while the block is idle.
// Timing:
//   Entries sit in a circular buffer in one synchronous RAM (registered read
//   data). A set walks backward from the tail one entry per cycle, moving
//   later deadlines up by one slot. A set on a full queue is rejected without
//   busy rising; the result follows in the next cycle. A tick reads the head
//   once per cycle; each result is held until it is known whether more
//   follow, the last shown in the cycle busy falls. A new request can be
//   taken in the cycle busy falls.
// Reset:
//   rst (synchronous) empties the queue, clears the tick count and phase and
//   sets switch_period to 10. RAM contents are not cleared.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int HANDLE_BITS = DefHandleBits
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   mode,
  input  logic [PortHandleW-1:0] handle,
  input  logic [TickBits-1:0]    delay,
  output logic                   result_valid,
  output logic [1:0]             kind,
  output logic [PortHandleW-1:0] expired_handle,
  output logic                   last,
  input  logic                   cfg_we,
  input  logic [PeriodBits-1:0]  cfg_wdata
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = TickBits + HANDLE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INS  = 4'b0010,
    ST_PUT  = 4'b0100,
    ST_POP  = 4'b1000
  } state_t;

  state_t                  state;
  logic [TickBits-1:0]     tick_count;
  logic [PeriodBits-1:0]   switch_phase;
  logic [PeriodBits-1:0]   switch_period;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        entry_count;
  logic [CNT_W-1:0]        slot;
  logic [TickBits-1:0]     ins_deadline;
  logic [HANDLE_BITS-1:0]  ins_handle;
  logic                    pend_valid;
  kind_t                   pend_kind;
  logic [HANDLE_BITS-1:0]  pend_handle;

  // logical index -> RAM address, wrapping at the queue depth
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // handle width conversion between port and storage
  logic [PortHandleW+HANDLE_BITS-1:0] handle_wide;
  logic [HANDLE_BITS-1:0]             handle_store;
  logic [PortHandleW+HANDLE_BITS-1:0] store_wide;
  logic [PortHandleW+HANDLE_BITS-1:0] pend_wide;
  assign handle_wide  = {{HANDLE_BITS{1'b0}}, handle};
  assign handle_store = handle_wide[HANDLE_BITS-1:0];
  assign store_wide   = {{PortHandleW{1'b0}}, handle_store};
  assign pend_wide    = {{PortHandleW{1'b0}}, pend_handle};

  // RAM ports
  logic                ram_we;
  logic [CNT_W-1:0]    rd_ofs;
  logic [IDX_W-1:0]    ram_raddr;
  logic [IDX_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;
  logic [TickBits-1:0] rd_deadline;
  logic [HANDLE_BITS-1:0] rd_handle;

  assign rd_deadline = ram_rdata[DATA_W-1:HANDLE_BITS];
  assign rd_handle   = ram_rdata[HANDLE_BITS-1:0];

  // decisions taken on the entry read last cycle
  logic move_up;
  logic expire;
  assign move_up = rd_deadline > ins_deadline;
  assign expire  = (entry_count != '0) && (rd_deadline <= tick_count);

  // tick phase update
  logic [PeriodBits-1:0] phase_inc;
  logic                  switch_due;
  assign phase_inc  = switch_phase + PeriodBits'(1);
  assign switch_due = (phase_inc >= switch_period) || (switch_period == '0);

  logic accept;
  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // RAM address and write control
  always_comb begin
    ram_we    = 1'b0;
    rd_ofs    = '0;
    ram_wdata = {ins_deadline, ins_handle};
    case (state)
      ST_IDLE: begin
        rd_ofs = mode ? '0 : entry_count - CNT_W'(1);
      end
      ST_INS: begin
        ram_we = 1'b1;
        rd_ofs = slot - CNT_W'(2);
        if (move_up) begin
          ram_wdata = ram_rdata;
        end
      end
      ST_PUT: begin
        ram_we = 1'b1;
      end
      ST_POP: begin
        rd_ofs = CNT_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = phys(head, rd_ofs);
  assign ram_waddr = phys(head, slot);

  sdtq_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (DATA_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_period <= PeriodReset;
    end else if (cfg_we) begin
      switch_period <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_count   <= '0;
      switch_phase <= '0;
      head         <= '0;
      entry_count  <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && !mode) begin
            if (entry_count == CNT_W'(QUEUE_DEPTH)) begin
              // queue full: reject at once
              result_valid   <= 1'b1;
              kind           <= KIND_REJECT;
              expired_handle <= store_wide[PortHandleW-1:0];
              last           <= 1'b1;
            end else begin
              ins_deadline <= tick_count + delay;
              ins_handle   <= handle_store;
              slot         <= entry_count;
              state        <= (entry_count == '0) ? ST_PUT : ST_INS;
            end
          end else if (accept) begin
            tick_count   <= tick_count + TickBits'(1);
            switch_phase <= switch_due ? '0 : phase_inc;
            pend_valid   <= switch_due;
            pend_kind    <= KIND_SWITCH;
            pend_handle  <= '0;
            state        <= ST_POP;
          end
        end
        ST_INS: begin
          // walk backward from the tail
          if (move_up) begin
            slot <= slot - CNT_W'(1);
            if (slot == CNT_W'(1)) begin
              state <= ST_PUT;
            end
          end else begin
            entry_count <= entry_count + CNT_W'(1);
            state       <= ST_IDLE;
          end
        end
        ST_PUT: begin
          entry_count <= entry_count + CNT_W'(1);
          state       <= ST_IDLE;
        end
        ST_POP: begin
          // a held result goes out once it is known whether more follow
          if (pend_valid) begin
            result_valid   <= 1'b1;
            kind           <= pend_kind;
            expired_handle <= pend_wide[PortHandleW-1:0];
            last           <= !expire;
          end
          if (expire) begin
            pend_valid  <= 1'b1;
            pend_kind   <= KIND_EXPIRED;
            pend_handle <= rd_handle;
            head        <= (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
            entry_count <= entry_count - CNT_W'(1);
          end else begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // no held result survives the end of a tick
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held result left behind in idle");

  // a set on a full queue is rejected in the next cycle
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && !mode && entry_count == CNT_W'(QUEUE_DEPTH))
      |=> (result_valid && kind == KIND_REJECT && last))
    else $error("missing reject result");

  // sets never produce results other than a reject
  a_set_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS || state == ST_PUT) |-> !result_valid || kind == KIND_REJECT)
    else $error("unexpected result during insert");

  // the tail never grows past the depth on insert
  a_no_full_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT) |-> entry_count < CNT_W'(QUEUE_DEPTH))
    else $error("insert into a full queue");
`endif

endmodule

// ===== tb/sv/tb_sorted_deadline_timer_queue.sv =====
// Self-checking testbench for the sorted deadline timer queue.
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue;
  import sdtq_pkg::*;

  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam int   CycleLimit = 200000;
  localparam int   SettleCycles = 40;
  localparam int   PhaseCount = 5;
  localparam logic [PortHandleW-1:0] HandleMask = PortHandleW'((1 << DefHandleBits) - 1);

  typedef struct packed {
    logic                   mode;
    logic [PortHandleW-1:0] handle;
    logic [TickBits-1:0]    delay;
  } timer_req_t;

  typedef struct {
    kind_t                  kind;
    logic [PortHandleW-1:0] handle;
    logic                   last;
  } timer_result_t;

  // DUT connections
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   mode = MODE_SET;
  logic [PortHandleW-1:0] handle = '0;
  logic [TickBits-1:0]    delay = '0;
  logic                   result_valid;
  logic [1:0]             kind;
  logic [PortHandleW-1:0] expired_handle;
  logic                   last;
  logic                   cfg_we = 1'b0;
  logic [PeriodBits-1:0]  cfg_wdata = '0;

  // Shadow state of the timer queue
  logic [TickBits-1:0]    shadow_ticks = '0;
  logic [PeriodBits-1:0]  shadow_phase = '0;
  logic [PeriodBits-1:0]  shadow_period = PeriodReset;
  logic [TickBits-1:0]    shadow_deadlines[$];
  logic [PortHandleW-1:0] shadow_handles[$];

  timer_req_t    pending_reqs[$];
  timer_result_t due_results[$];
  int            sender_idle_pct = 0;
  int            mismatches = 0;
  int            accepted = 0;
  int            cycle_count = 0;
  int            seen_expired = 0;
  int            seen_switch = 0;
  int            seen_reject = 0;

  // Phase plan: switch period, sender idle percentage, request count
  logic [PeriodBits-1:0] period_plan[PhaseCount] = '{8'd1, 8'd255, 8'd0, 8'd200, 8'd3};
  int idle_plan[PhaseCount]  = '{0, 86, 0, 27, 27};
  int count_plan[PhaseCount] = '{60, 50, 40, 40, 60};

  sorted_deadline_timer_queue u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .handle(handle),
    .delay(delay),
    .result_valid(result_valid),
    .kind(kind),
    .expired_handle(expired_handle),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic timer_result_t make_result(kind_t k, logic [PortHandleW-1:0] h);
    timer_result_t r;
    r.kind = k;
    r.handle = h;
    r.last = 1'b0;
    return r;
  endfunction

  // Advance the shadow queue by one request and queue up what it should emit
  function automatic void predict_request(logic m, logic [PortHandleW-1:0] h,
                                          logic [TickBits-1:0] d);
    logic [TickBits-1:0] due_at;
    int                  pos;
    timer_result_t       batch[$];
    h = h & HandleMask;
    if (m == MODE_SET) begin
      if (shadow_deadlines.size() >= DefQueueDepth) begin
        batch.push_back(make_result(KIND_REJECT, h));
      end else begin
        // insert after every entry due at the same tick or earlier
        due_at = shadow_ticks + d;
        pos = 0;
        while (pos < shadow_deadlines.size() && shadow_deadlines[pos] <= due_at) pos++;
        shadow_deadlines.insert(pos, due_at);
        shadow_handles.insert(pos, h);
      end
    end else begin
      shadow_ticks = shadow_ticks + 1'b1;
      shadow_phase = shadow_phase + 1'b1;
      if (shadow_phase >= shadow_period || shadow_period == '0) begin
        shadow_phase = '0;
        batch.push_back(make_result(KIND_SWITCH, '0));
      end
      // pop everything due, head first
      while (shadow_deadlines.size() > 0 && shadow_deadlines[0] <= shadow_ticks) begin
        batch.push_back(make_result(KIND_EXPIRED, shadow_handles[0]));
        void'(shadow_deadlines.pop_front());
        void'(shadow_handles.pop_front());
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endfunction

  function automatic void queue_req(logic m, logic [PortHandleW-1:0] h,
                                    logic [TickBits-1:0] d);
    timer_req_t r;
    r.mode = m;
    r.handle = h;
    r.delay = d;
    pending_reqs.push_back(r);
  endfunction

  // Mostly short delays so entries expire; a few wrap or land far out
  function automatic timer_req_t random_req();
    timer_req_t r;
    int         pick;
    r.handle = PortHandleW'($urandom_range(255));
    r.mode = ($urandom_range(99) < 55) ? MODE_TICK : MODE_SET;
    pick = $urandom_range(99);
    if (pick < 70) r.delay = $urandom_range(24);
    else if (pick < 86) r.delay = $urandom_range(200);
    else if (pick < 96) r.delay = 32'hFFFF_FFFF - $urandom_range(8);
    else r.delay = $urandom();
    return r;
  endfunction

  // Request driver
  always @(posedge clk) begin
    timer_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(mode, handle, delay);
        accepted++;
      end
      // hold a request that is still waiting on busy
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_reqs.pop_front();
          start <= 1'b1;
          mode <= nxt.mode;
          handle <= nxt.handle;
          delay <= nxt.delay;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && result_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d handle %0h last %0b",
                                  kind, expired_handle, last));
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (expired_handle !== want.handle)
          report_mismatch($sformatf("handle %0h, want %0h", expired_handle, want.handle));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        case (want.kind)
          KIND_EXPIRED: seen_expired++;
          KIND_SWITCH:  seen_switch++;
          default:      seen_reject++;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Wait until nothing is in flight, then let the block settle
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || start || busy || due_results.size() > 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_period(input logic [PeriodBits-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_period = v;
  endtask

  // Stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, equal deadlines, wrapped deadline, full queue
    queue_req(MODE_SET, 8'hFF, 32'd0);
    queue_req(MODE_SET, 8'hA5, 32'd3);
    queue_req(MODE_SET, 8'h5A, 32'd3);
    queue_req(MODE_TICK, 8'h00, 32'd0);
    queue_req(MODE_SET, 8'h00, 32'hFFFF_FFFF);
    queue_req(MODE_TICK, 8'hFF, 32'hFFFF_FFFF);
    queue_req(MODE_TICK, 8'h00, 32'd0);
    for (int i = 0; i < DefQueueDepth; i++) queue_req(MODE_SET, PortHandleW'(8'h10 + i), 32'd4);
    queue_req(MODE_SET, 8'hC3, 32'd0);
    wait_quiet();

    // random phases; the 200 -> 3 step lowers the period below the phase
    for (int p = 0; p < PhaseCount; p++) begin
      write_period(period_plan[p]);
      sender_idle_pct = idle_plan[p];
      repeat (count_plan[p]) pending_reqs.push_back(random_req());
      wait_quiet();
    end

    $display("Requests accepted: %0d over %0d period settings", accepted, PhaseCount + 1);
    $display("Results checked: %0d expired, %0d task switches, %0d rejects",
             seen_expired, seen_switch, seen_reject);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
